// ===== src/rme_pkg.sv =====
// Shared types for the modular exponentiation controller and datapath.
package rme_pkg;

  // Source of the value that goes to the result register.
  typedef enum logic [1:0] {
    RES_ONE,
    RES_ZERO,
    RES_ACC
  } res_sel_t;

  // Commands from the controller to the datapath, driven combinationally by the controller.
  typedef struct packed {
    logic     load;       // capture operands of a new word
    logic     red_step;   // one bit of the base reduction
    logic     init_acc;   // take the reduced base and set the accumulator
    logic     mul_start;  // load the multiplier operands
    logic     mul_sq;     // with mul_start: square the base, else acc * base
    logic     mul_step;   // one bit of the shift-and-add multiply
    logic     wb_acc;     // product to the accumulator
    logic     wb_base;    // product to the base
    logic     exp_shift;  // drop the exponent's lowest bit
    logic     res_load;   // load the result register
    res_sel_t res_sel;
  } rme_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_upper_zero;
    logic mod_zero;
    logic cnt_zero;
    logic mul_done;
  } rme_sts_t;

endpackage

// ===== src/rme_datapath.sv =====
// Datapath: operand registers, bit-serial reduction and shift-and-add modular multiplier.
module rme_datapath
  import rme_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] modulus,
  input  logic [VALUE_BITS-1:0] public_exponent,
  input  logic [VALUE_BITS-1:0] private_exponent,
  input  logic                  mode,
  input  logic [VALUE_BITS-1:0] base_value,
  input  rme_cmd_t              cmd,
  output rme_sts_t              sts,
  output logic [VALUE_BITS-1:0] result_value
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] mod_r;
  logic [VALUE_BITS-1:0] exp_r;
  logic [VALUE_BITS-1:0] base_r;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] mx;
  logic [VALUE_BITS-1:0] my;
  logic [VALUE_BITS-1:0] mp;
  logic [VALUE_BITS-1:0] result;
  logic [CNT_W-1:0]      cnt;

  logic [VALUE_BITS:0]   rem_wide;
  logic [VALUE_BITS-1:0] rem_next;
  logic [VALUE_BITS-1:0] mp_next;
  logic [VALUE_BITS-1:0] mx_next;

  // (a + b) mod m, given that both operands are already below m.
  function automatic logic [VALUE_BITS-1:0] add_mod(
    input logic [VALUE_BITS-1:0] a,
    input logic [VALUE_BITS-1:0] b,
    input logic [VALUE_BITS-1:0] m
  );
    logic [VALUE_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[VALUE_BITS-1:0];
  endfunction

  // Restoring reduction: shift the next base bit into the remainder.
  always_comb begin
    rem_wide = {rem, base_r[VALUE_BITS-1]};
    if (rem_wide >= {1'b0, mod_r}) begin
      rem_wide = rem_wide - {1'b0, mod_r};
    end
    rem_next = rem_wide[VALUE_BITS-1:0];
  end

  assign mp_next = my[0] ? add_mod(mp, mx, mod_r) : mp;
  assign mx_next = add_mod(mx, mx, mod_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r  <= modulus;
      exp_r  <= mode ? private_exponent : public_exponent;
      base_r <= base_value;
      rem    <= '0;
      cnt    <= CNT_W'(VALUE_BITS - 1);
    end else if (cmd.red_step) begin
      rem    <= rem_next;
      base_r <= {base_r[VALUE_BITS-2:0], 1'b0};
      cnt    <= cnt - 1'b1;
    end else if (cmd.init_acc) begin
      base_r <= rem;
      acc    <= (mod_r == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
    end else if (cmd.wb_acc) begin
      acc    <= mp;
    end else if (cmd.wb_base) begin
      base_r <= mp;
    end
    if (cmd.exp_shift) begin
      exp_r <= exp_r >> 1;
    end
    if (cmd.mul_start) begin
      mx <= base_r;
      my <= cmd.mul_sq ? base_r : acc;
      mp <= '0;
    end else if (cmd.mul_step) begin
      mx <= mx_next;
      my <= my >> 1;
      mp <= mp_next;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ONE:  result <= VALUE_BITS'(1);
        RES_ZERO: result <= '0;
        RES_ACC:  result <= acc;
        default:  result <= acc;
      endcase
    end
  end

  assign sts.exp_zero       = (exp_r == '0);
  assign sts.exp_lsb        = exp_r[0];
  assign sts.exp_upper_zero = (exp_r[VALUE_BITS-1:1] == '0);
  assign sts.mod_zero       = (mod_r == '0);
  assign sts.cnt_zero       = (cnt == '0);
  assign sts.mul_done       = (my == '0);

  assign result_value = result;

endmodule

// ===== src/rme_ctrl.sv =====
// Controller: sequences reduction, multiplies and squarings, and owns the word handshakes.
module rme_ctrl
  import rme_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rme_sts_t sts,
  output rme_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE,
    START,
    REDUCE,
    INIT,
    CHECK,
    MUL_A,
    CHECK2,
    MUL_S,
    FINISH
  } state_t;

  state_t   state;
  state_t   state_next;
  res_sel_t res_sel;
  res_sel_t res_sel_next;
  logic     out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.res_sel  = res_sel;
    state_next   = state;
    res_sel_next = res_sel;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = START;
        end
      end
      START: begin
        if (sts.exp_zero) begin
          res_sel_next = RES_ONE;
          state_next   = FINISH;
        end else if (sts.mod_zero) begin
          res_sel_next = RES_ZERO;
          state_next   = FINISH;
        end else begin
          state_next = REDUCE;
        end
      end
      REDUCE: begin
        cmd.red_step = 1'b1;
        if (sts.cnt_zero) begin
          state_next = INIT;
        end
      end
      INIT: begin
        cmd.init_acc = 1'b1;
        state_next   = CHECK;
      end
      CHECK: begin
        if (sts.exp_zero) begin
          res_sel_next = RES_ACC;
          state_next   = FINISH;
        end else if (sts.exp_lsb) begin
          cmd.mul_start = 1'b1;
          state_next    = MUL_A;
        end else begin
          state_next = CHECK2;
        end
      end
      MUL_A: begin
        if (sts.mul_done) begin
          cmd.wb_acc = 1'b1;
          state_next = CHECK2;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      CHECK2: begin
        if (sts.exp_upper_zero) begin
          cmd.exp_shift = 1'b1;
          res_sel_next  = RES_ACC;
          state_next    = FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sq    = 1'b1;
          state_next    = MUL_S;
        end
      end
      MUL_S: begin
        if (sts.mul_done) begin
          cmd.wb_base   = 1'b1;
          cmd.exp_shift = 1'b1;
          state_next    = CHECK;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_sel   <= RES_ACC;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rsa_modular_exponent.sv =====
// Top level of the RSA modular exponentiation block: register file and core.
//
//   Channel  Direction  Handshake           Payload
//   in       sink       in_valid/in_stall   mode, base_value
//   out      source     out_valid/out_stall result_value
//   cfg      APB slave  psel/penable/pready modulus, public_exponent, private_exponent
//
// A word is worked on alone. After the load and the START state the base is
// reduced modulo the modulus one bit per cycle, then the exponent is scanned
// from its lowest bit by square-and-multiply. Each modular multiply runs on
// one shared shift-and-add unit, one multiplier bit per cycle. The top bit of
// the exponent needs no squaring, and a zero exponent or modulus skips the
// reduction and the multiplies and goes straight to the result register.
// Reset is synchronous and active high; it clears the controller and sets the
// registers to modulus 2 and both exponents 0. The finished result sits in an
// output register, so a new word is taken while the previous one is stalled;
// the controller only waits at the end of a word if that register is still
// occupied. Registers are meant to be written only while the block is idle.
module rsa_modular_exponent
  import rme_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [VALUE_BITS-1:0] base_value,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] result_value,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [((VALUE_BITS > 32) ? 5 : 4)-1:0] paddr,
  input  logic [((VALUE_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((VALUE_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                  pready
);

  localparam int DATA_W   = (VALUE_BITS > 32) ? 64 : 32;
  localparam int ADDR_LSB = (VALUE_BITS > 32) ? 3 : 2;
  localparam int ADDR_W   = ADDR_LSB + 2;

  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

  logic [VALUE_BITS-1:0] modulus;
  logic [VALUE_BITS-1:0] public_exponent;
  logic [VALUE_BITS-1:0] private_exponent;
  logic [1:0]            reg_index;
  logic                  reg_write;

  rme_cmd_t cmd;
  rme_sts_t sts;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:ADDR_LSB];
  assign reg_write = psel && penable && pwrite && pready;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= VALUE_BITS'(2);
      public_exponent  <= '0;
      private_exponent <= '0;
    end else if (reg_write) begin
      case (reg_index)
        REG_MODULUS:     modulus          <= pwdata[VALUE_BITS-1:0];
        REG_PUBLIC_EXP:  public_exponent  <= pwdata[VALUE_BITS-1:0];
        REG_PRIVATE_EXP: private_exponent <= pwdata[VALUE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the registers, zero-extended to the bus width.
  always_comb begin
    case (reg_index)
      REG_MODULUS:     prdata = DATA_W'(modulus);
      REG_PUBLIC_EXP:  prdata = DATA_W'(public_exponent);
      REG_PRIVATE_EXP: prdata = DATA_W'(private_exponent);
      default:         prdata = '0;
    endcase
  end

  rme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rme_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk              (clk),
    .modulus          (modulus),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .mode             (mode),
    .base_value       (base_value),
    .cmd              (cmd),
    .sts              (sts),
    .result_value     (result_value)
  );

endmodule

// ===== tb/sv/rsa_modular_exponent_tb.sv =====
// Self-checking testbench for the RSA modular exponentiation block.
`timescale 1ns / 100ps

module rsa_modular_exponent_tb;

  localparam int VALUE_BITS = 16;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  // Register indexes; each register lies at byte address 4 * index.
  localparam int REG_MODULUS     = 0;
  localparam int REG_PUBLIC_EXP  = 1;
  localparam int REG_PRIVATE_EXP = 2;
  localparam int REG_UNMAPPED    = 3;

  // Length of the deliberate output hold-off, and the words offered during it.
  localparam int HOLD_CYCLES   = 1500;
  localparam int PRESSURE_WORDS = 8;

  // Random words per register setting; twelve settings give about 1650 words.
  localparam int RANDOM_WORDS_PER_SETTING = 137;

  // Cycles allowed after the last result for anything stray to show up. This
  // covers one more word with a full 16-bit exponent.
  localparam int SETTLE_CYCLES = 700;

  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } exp_mode_t;

  // One outstanding word: what went in, and the result it must produce.
  typedef struct {
    exp_mode_t             mode;
    logic [VALUE_BITS-1:0] base;
    logic [VALUE_BITS-1:0] result_value;
  } pending_word_t;

  // Clock and reset. Every input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  mode       = 1'b0;
  logic [VALUE_BITS-1:0] base_value = '0;

  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [VALUE_BITS-1:0] result_value;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]  paddr   = '0;
  logic [DATA_BITS-1:0]  pwdata  = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  // Our own copy of the register file, updated as each write goes out.
  logic [VALUE_BITS-1:0] key_modulus = VALUE_BITS'(2);
  logic [VALUE_BITS-1:0] key_public  = '0;
  logic [VALUE_BITS-1:0] key_private = '0;

  pending_word_t expected_results[$];

  int mismatch_count = 0;
  int words_sent     = 0;
  int settings_used  = 0;

  // Idling percentages, changed by the tests phase by phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // A hold-off is requested by bumping the token; the stall process counts it out.
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  always #5 clk = ~clk;

  rsa_modular_exponent #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .base_value  (base_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_value(result_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Square-and-multiply over the exponent bits. An exponent of zero gives one
  // whatever the modulus; a zero modulus with any other exponent gives zero.
  // Products of two 16-bit residues fit easily in 64 bits.
  function automatic logic [VALUE_BITS-1:0] modexp_expected(
    input logic [VALUE_BITS-1:0] base,
    input logic [VALUE_BITS-1:0] exponent,
    input logic [VALUE_BITS-1:0] modulus
  );
    longint unsigned acc;
    longint unsigned square;
    longint unsigned bits_left;
    longint unsigned m;
    if (exponent == 0) begin
      return VALUE_BITS'(1);
    end
    if (modulus == 0) begin
      return '0;
    end
    m         = modulus;
    square    = base % m;
    acc       = 1 % m;
    bits_left = exponent;
    while (bits_left != 0) begin
      if (bits_left[0]) begin
        acc = (acc * square) % m;
      end
      square    = (square * square) % m;
      bits_left = bits_left >> 1;
    end
    return acc[VALUE_BITS-1:0];
  endfunction

  // Exponent with a random number of significant bits, the top one always set,
  // so that the run time of a word is kept under control.
  function automatic logic [VALUE_BITS-1:0] random_exponent(input int max_bits);
    int              nbits;
    longint unsigned value;
    nbits = $urandom_range(max_bits, 0);
    if (nbits == 0) begin
      return '0;
    end
    value = $urandom;
    value = (value | (64'd1 << (nbits - 1))) & ((64'd1 << nbits) - 1);
    return value[VALUE_BITS-1:0];
  endfunction

  // Bases lean towards the edges: zero, all ones, the modulus and the value just
  // below it, with random residues and plenty of plain random values in between.
  function automatic logic [VALUE_BITS-1:0] random_base();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return (key_modulus != 0) ? VALUE_BITS'($urandom % key_modulus) : '0;
      3: return key_modulus - VALUE_BITS'($urandom_range(1, 0));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Receiver side. Outside a hold-off the stall is random at the current rate.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every result word accepted is checked against the oldest expectation.
  always @(posedge clk) begin : check_result
    pending_word_t oldest;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result_value arrived with nothing expected: actual %0d", result_value);
        mismatch_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (result_value !== oldest.result_value) begin
          $error("result_value mismatch: expected %0d, actual %0d (mode %0d, base %0d)",
                 oldest.result_value, result_value, oldest.mode, oldest.base);
          mismatch_count++;
        end
      end
    end
  end

  // One register port transfer: setup cycle, then access until pready.
  task automatic bus_access(input int index, input logic is_write,
                            input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_BITS'(index * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads a mapped register back and compares it with our copy.
  task automatic check_register(input int index);
    logic [DATA_BITS-1:0]  rdata;
    logic [VALUE_BITS-1:0] held;
    case (index)
      REG_MODULUS:    held = key_modulus;
      REG_PUBLIC_EXP: held = key_public;
      default:        held = key_private;
    endcase
    bus_access(index, 1'b0, '0, rdata);
    if (rdata[VALUE_BITS-1:0] !== held) begin
      $error("register %0d readback mismatch: expected %0d, actual %0d",
             index, held, rdata[VALUE_BITS-1:0]);
      mismatch_count++;
    end
  endtask

  // Writes a register and mirrors it; a write beyond the list changes nothing.
  task automatic write_register(input int index, input logic [VALUE_BITS-1:0] value);
    logic [DATA_BITS-1:0] unused;
    bus_access(index, 1'b1, DATA_BITS'(value), unused);
    case (index)
      REG_MODULUS:     key_modulus = value;
      REG_PUBLIC_EXP:  key_public  = value;
      REG_PRIVATE_EXP: key_private = value;
      default: ;
    endcase
    if (index != REG_UNMAPPED) begin
      check_register(index);
    end
  endtask

  // Loads a whole key. Only called while the block is idle.
  task automatic load_key(input logic [VALUE_BITS-1:0] modulus,
                          input logic [VALUE_BITS-1:0] public_exp,
                          input logic [VALUE_BITS-1:0] private_exp);
    write_register(REG_MODULUS, modulus);
    write_register(REG_PUBLIC_EXP, public_exp);
    write_register(REG_PRIVATE_EXP, private_exp);
    settings_used++;
  endtask

  // Offers one word after a random idle gap and records what it must produce
  // once the block has accepted it. Valid stays high for a following word.
  task automatic send_word(input exp_mode_t word_mode, input logic [VALUE_BITS-1:0] base);
    pending_word_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= word_mode;
    base_value <= base;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    entry.mode         = word_mode;
    entry.base         = base;
    entry.result_value = modexp_expected(base,
                                         (word_mode == MODE_DECRYPT) ? key_private : key_public,
                                         key_modulus);
    expected_results.push_back(entry);
    words_sent++;
  endtask

  // Drops valid and waits until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // After reset the modulus is two and both exponents zero, so every word
  // must give one.
  task automatic test_reset_defaults();
    check_register(REG_MODULUS);
    check_register(REG_PUBLIC_EXP);
    check_register(REG_PRIVATE_EXP);
    send_word(MODE_ENCRYPT, VALUE_BITS'(16'h1234));
    send_word(MODE_DECRYPT, '1);
    drain_results();
  endtask

  // The classic small key: n = 61 * 53, e = 17, d = 2753. A base of the
  // modulus or above has to be reduced before the first multiply.
  task automatic test_textbook_key();
    load_key(VALUE_BITS'(3233), VALUE_BITS'(17), VALUE_BITS'(2753));
    send_word(MODE_ENCRYPT, VALUE_BITS'(65));
    send_word(MODE_DECRYPT, VALUE_BITS'(2790));
    send_word(MODE_ENCRYPT, '0);
    send_word(MODE_DECRYPT, '1);
    send_word(MODE_ENCRYPT, VALUE_BITS'(3233));
    send_word(MODE_DECRYPT, VALUE_BITS'(3232));
    drain_results();
  endtask

  // A zero modulus: a zero exponent still gives one, any other gives zero.
  // A modulus of one: zero exponent gives one, any other gives zero.
  task automatic test_degenerate_moduli();
    load_key('0, '0, VALUE_BITS'(5));
    send_word(MODE_ENCRYPT, VALUE_BITS'(77));
    send_word(MODE_DECRYPT, VALUE_BITS'(77));
    drain_results();
    load_key(VALUE_BITS'(1), '0, '1);
    send_word(MODE_ENCRYPT, '1);
    send_word(MODE_DECRYPT, '1);
    drain_results();
  endtask

  // All registers at their top value: the longest exponent and the largest
  // products the datapath can see.
  task automatic test_widest_operands();
    load_key('1, '1, '1);
    send_word(MODE_ENCRYPT, '1);
    send_word(MODE_DECRYPT, '1 - VALUE_BITS'(1));
    send_word(MODE_ENCRYPT, VALUE_BITS'(2));
    send_word(MODE_DECRYPT, VALUE_BITS'(16'h8000));
    drain_results();
  endtask

  // A write past the last register must leave the key as it was.
  task automatic test_unmapped_register();
    load_key(VALUE_BITS'(60491), VALUE_BITS'(7), VALUE_BITS'(17143));
    write_register(REG_UNMAPPED, '1);
    check_register(REG_MODULUS);
    check_register(REG_PUBLIC_EXP);
    check_register(REG_PRIVATE_EXP);
    send_word(MODE_ENCRYPT, VALUE_BITS'(12345));
    send_word(MODE_DECRYPT, VALUE_BITS'(54321));
    drain_results();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the output register and the core both fill and the input has to stall.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_key(VALUE_BITS'(3233), VALUE_BITS'(3), VALUE_BITS'(5));
    hold_token <= hold_token + 1;
    for (int i = 0; i < PRESSURE_WORDS; i++) begin
      send_word(exp_mode_t'($urandom_range(1)), random_base());
    end
    drain_results();
  endtask

  // Random words under four idling patterns, three keys each. One key in the
  // run uses full-length exponents; the rest keep them short.
  task automatic test_random_traffic();
    logic [VALUE_BITS-1:0] modulus;
    int                    max_bits;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int setting = 0; setting < 3; setting++) begin
        case ($urandom_range(7))
          0:       modulus = VALUE_BITS'($urandom_range(300, 2));
          1:       modulus = VALUE_BITS'($urandom_range(1, 0));
          2:       modulus = '1;
          default: modulus = VALUE_BITS'($urandom) | VALUE_BITS'(16'h8000);
        endcase
        max_bits = (phase * 3 + setting == 5) ? VALUE_BITS : 6;
        drain_results();
        load_key(modulus, random_exponent(max_bits), random_exponent(max_bits));
        for (int i = 0; i < RANDOM_WORDS_PER_SETTING; i++) begin
          send_word(exp_mode_t'($urandom_range(1)), random_base());
        end
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_textbook_key();
    test_degenerate_moduli();
    test_widest_operands();
    test_unmapped_register();
    test_backpressure();
    test_random_traffic();

    // Give any stray result time to appear before the verdict.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end

    $display("Run covered %0d words over %0d key settings, both exponent modes,",
             words_sent, settings_used);
    $display("zero and unit moduli, an unmapped write and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, set several times above the slowest correct run.
  initial begin
    #50ms;
    $display("Watchdog expired with %0d results outstanding.", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
